@@ rtl/wmr_pkg.sv @@
// Shared widths for the window mean and range core.
package wmr_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int FILL_W     = 6;
  localparam int OUT_DATA_W = 72;

endpackage

@@ rtl/window_mean_and_range_core.sv @@
// Top level: sliding window mean and range over signed Q16.16 samples.
//
//  channel   dir  width  contents
//  s_*       in   32     tdata = sample
//  m_*       out  72     tdata = mean, spread, fill
//
//  The one-bit-per-cycle divider sets when a result is ready; the min/max scan
//  of the ring (one read port) runs alongside it and hides behind it while
//  fill <= SUM_W.
//  s_tready is high only while idle; a finished result waits in the output
//  register, so the next sample is taken while m_tready is low.
//  Reset clears the write slot, fill count and running sum; no clearing pass.
module window_mean_and_range_core
  import wmr_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] mean, [63:32] spread, [69:64] fill
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                     state;
  logic signed [SAMPLE_W-1:0] samp;
  logic [IDX_W-1:0]           slot;
  logic [CNT_W-1:0]           fill;
  logic signed [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]           idx;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;

  logic                       full;
  logic [IDX_W-1:0]           rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       wr_en;
  logic signed [SUM_W-1:0]    sum_next;
  logic [SUM_W-1:0]           sum_mag;
  logic                       div_start;
  logic                       div_done;
  logic [SUM_W-1:0]           quo;
  logic [SAMPLE_W-1:0]        mean_full;
  logic                       out_free;
  logic                       out_load;

  assign full      = (fill == CNT_W'(WINDOW));
  assign s_tready  = (state == ST_IDLE);
  assign rd_addr   = (state == ST_SCAN) ? idx[IDX_W-1:0] : slot;
  assign wr_en     = (state == ST_UPDATE);
  assign div_start = (state == ST_SCAN) && (idx == '0);
  assign sum_mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign mean_full = sum[SUM_W-1] ? (-quo[SAMPLE_W-1:0]) : quo[SAMPLE_W-1:0];
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == ST_FINISH) && div_done && out_free;

  always_comb begin
    sum_next = sum + SUM_W'(samp);
    if (full) begin
      sum_next = sum_next - SUM_W'(rd_data);
    end
  end

  wmr_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (samp),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wmr_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum_mag),
    .den   (fill),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      slot     <= '0;
      fill     <= '0;
      sum      <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            samp  <= s_tdata;
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sum  <= sum_next;
          fill <= full ? fill : fill + CNT_W'(1);
          slot <= (slot == IDX_W'(WINDOW - 1)) ? '0 : slot + IDX_W'(1);
          idx  <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          idx <= idx + CNT_W'(1);
          if (idx == CNT_W'(1)) begin
            lo <= rd_data;
            hi <= rd_data;
          end else if (idx != '0) begin
            if (rd_data < lo) lo <= rd_data;
            if (rd_data > hi) hi <= rd_data;
          end
          if (idx == fill) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            m_tdata  <= {{(OUT_DATA_W - 2*SAMPLE_W - FILL_W){1'b0}},
                         FILL_W'(fill),
                         SAMPLE_W'(hi - lo),
                         mean_full};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW)) else $error("fill count above window");

  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && div_done |-> quo[SUM_W-1:SAMPLE_W] == '0)
    else $error("mean magnitude out of range");

  a_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> hi >= lo) else $error("scan max below min");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_UPDATE) else $error("accept did not start update");

endmodule

@@ rtl/wmr_ring.sv @@
// Sample ring memory, one write port and one registered read port.
module wmr_ring
  import wmr_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/wmr_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module wmr_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_BW = $clog2(NUM_W + 1);

  logic              active;
  logic [CNT_BW-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic [DEN_W-1:0]  diff;
  logic              qbit;
  logic [DEN_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    diff     = trial[DEN_W-1:0] - den;
    qbit     = (trial >= {1'b0, den});
    rem_next = qbit ? diff : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      cnt    <= CNT_BW'(NUM_W);
      rem    <= '0;
      quo    <= num;
    end else if (active) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], qbit};
      cnt <= cnt - CNT_BW'(1);
      if (cnt == CNT_BW'(1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !active) else $error("divider done while active");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    active && den != '0 |-> rem < den) else $error("remainder not below divisor");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    active && cnt == CNT_BW'(1) && !start |=> done) else $error("divider missed done");

endmodule
